>>> src/scan_code_set1_decoder_top_macros.svh
// Assertion macros shared by the scan code decoder RTL.
// Included by the modules that check their own logic; needs no other file.
`ifndef SCAN_CODE_SET1_DECODER_TOP_MACROS_SVH
`define SCAN_CODE_SET1_DECODER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/scd_pkg.sv
// Shared types, constants and helper functions of the set-1 scan code decoder.
// Used by scd_core and scan_code_set1_decoder_top; depends on nothing.
package scd_pkg;

  localparam int QueueDepth = 256;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int EntryW     = 8;
  localparam int CodeW      = 7;

  typedef enum logic {
    OpRx  = 1'b0,
    OpPop = 1'b1
  } op_e;

  localparam logic [7:0] PrefixExt   = 8'hE0;
  localparam logic [7:0] PrefixPause = 8'hE1;
  localparam logic [7:0] MaxCode     = 8'h6D;

  localparam logic [CodeW-1:0] CodeCtrl   = 7'h1D;
  localparam logic [CodeW-1:0] CodeAlt    = 7'h38;
  localparam logic [CodeW-1:0] CodeLShift = 7'h2A;
  localparam logic [CodeW-1:0] CodeRShift = 7'h36;
  localparam logic [CodeW-1:0] CodeCaps   = 7'h3A;
  localparam logic [CodeW-1:0] CodeNum    = 7'h45;
  localparam logic [CodeW-1:0] CodeScroll = 7'h46;

  // Bit positions of the modifier and lock flags.
  localparam int ModShift   = 0;
  localparam int ModCtrl    = 1;
  localparam int ModAlt     = 2;
  localparam int LockScroll = 0;
  localparam int LockNum    = 1;
  localparam int LockCaps   = 2;

  // Per-request information that travels with the queue read.
  typedef struct packed {
    logic              fwd;
    logic [EntryW-1:0] fwd_entry;
    logic              empty;
    logic              led;
    logic [2:0]        leds;
    logic [2:0]        mods;
  } stage_t;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    if (idx == IdxW'(QueueDepth - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  function automatic logic [2:0] modifier_of(input logic [CodeW-1:0] code, input logic ext);
    logic [2:0] m;
    m = '0;
    if (code == CodeCtrl) begin
      m[ModCtrl] = 1'b1;
    end else if (code == CodeAlt) begin
      m[ModAlt] = 1'b1;
    end else if (!ext && (code == CodeLShift || code == CodeRShift)) begin
      m[ModShift] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic is_keypad(input logic [CodeW-1:0] code);
    return (code >= 7'h47 && code <= 7'h49) ||
           (code >= 7'h4B && code <= 7'h4D) ||
           (code >= 7'h4F && code <= 7'h53);
  endfunction

endpackage

>>> src/scd_ram.sv
// Generic single-clock RAM: one write port and one registered read port.
// Stand-alone; used by scd_core as the key queue storage.
module scd_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/scd_core.sv
// Decoder state and key queue: byte decoding, queue pointers and the queue RAM.
// Depends on scd_pkg, scd_ram and the assertion macro header.
`include "scan_code_set1_decoder_top_macros.svh"

module scd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic [7:0]                   rx_byte_i,
  output scd_pkg::stage_t              stage_o,
  output logic [scd_pkg::EntryW-1:0]   rdata_o
);

  logic [scd_pkg::IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [scd_pkg::CntW-1:0]   count_q, count_d;
  logic                       pend_ext_q, pend_ext_d;
  logic                       pend_pause_q, pend_pause_d;
  logic [2:0]                 mod_q, mod_d;
  logic [2:0]                 lock_q, lock_d;
  logic                       push;
  logic                       led;
  logic                       store_ext;
  logic [scd_pkg::CodeW-1:0]  code;
  logic [scd_pkg::EntryW-1:0] entry;

  assign code  = rx_byte_i[scd_pkg::CodeW-1:0];
  assign entry = {store_ext, code};

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    pend_ext_d   = pend_ext_q;
    pend_pause_d = pend_pause_q;
    mod_d        = mod_q;
    lock_d       = lock_q;
    push         = 1'b0;
    led          = 1'b0;
    store_ext    = 1'b0;

    if (op_i == scd_pkg::OpPop) begin
      if (count_q != '0) begin
        head_d  = scd_pkg::next_slot(head_q);
        count_d = count_q - 1'b1;
      end
    end else if (rx_byte_i == scd_pkg::PrefixExt || pend_pause_q) begin
      // The byte after a pause prefix only marks the next code extended.
      pend_ext_d   = 1'b1;
      pend_pause_d = 1'b0;
    end else if (rx_byte_i == scd_pkg::PrefixPause) begin
      pend_pause_d = 1'b1;
    end else if (rx_byte_i > scd_pkg::MaxCode) begin
      if (rx_byte_i[7] && code <= scd_pkg::MaxCode[scd_pkg::CodeW-1:0]) begin
        mod_d = mod_q & ~scd_pkg::modifier_of(code, pend_ext_q);
      end
      pend_ext_d   = 1'b0;
      pend_pause_d = 1'b0;
    end else begin
      push      = 1'b1;
      store_ext = pend_ext_q | (!lock_q[scd_pkg::LockNum] & scd_pkg::is_keypad(code));
      mod_d     = mod_q | scd_pkg::modifier_of(code, pend_ext_q);
      if (!pend_ext_q) begin
        case (code)
          scd_pkg::CodeCaps: begin
            lock_d[scd_pkg::LockCaps] = ~lock_q[scd_pkg::LockCaps];
            led = 1'b1;
          end
          scd_pkg::CodeNum: begin
            lock_d[scd_pkg::LockNum] = ~lock_q[scd_pkg::LockNum];
            led = 1'b1;
          end
          scd_pkg::CodeScroll: begin
            lock_d[scd_pkg::LockScroll] = ~lock_q[scd_pkg::LockScroll];
            led = 1'b1;
          end
          default: begin
            led = 1'b0;
          end
        endcase
      end
      pend_ext_d = 1'b0;
    end

    // A push into a full queue drops the oldest entry.
    if (push) begin
      tail_d = scd_pkg::next_slot(tail_q);
      if (count_q == scd_pkg::CntW'(scd_pkg::QueueDepth)) begin
        head_d = scd_pkg::next_slot(head_q);
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      pend_ext_q   <= 1'b0;
      pend_pause_q <= 1'b0;
      mod_q        <= '0;
      lock_q       <= '0;
    end else if (accept_i) begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      pend_ext_q   <= pend_ext_d;
      pend_pause_q <= pend_pause_d;
      mod_q        <= mod_d;
      lock_q       <= lock_d;
    end
  end

  // The RAM returns old data on a same-address write, so a key written into an
  // empty queue is forwarded to the head read instead.
  assign stage_o.fwd       = push && (head_d == tail_q);
  assign stage_o.fwd_entry = entry;
  assign stage_o.empty     = (count_d == '0);
  assign stage_o.led       = led;
  assign stage_o.leds      = lock_d;
  assign stage_o.mods      = mod_d;

  scd_ram #(
    .Depth (scd_pkg::QueueDepth),
    .Width (scd_pkg::EntryW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i && push),
    .waddr_i (tail_q),
    .wdata_i (entry),
    .re_i    (accept_i),
    .raddr_i (head_d),
    .rdata_o (rdata_o)
  );

  `SCD_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1,
    count_q <= scd_pkg::CntW'(scd_pkg::QueueDepth), "queue count exceeds depth")
  `SCD_ASSERT_IMPL(a_ptr_meet, clk_i, rst_ni, head_q == tail_q,
    count_q == '0 || count_q == scd_pkg::CntW'(scd_pkg::QueueDepth),
    "pointers meet with a partly filled queue")
  `SCD_ASSERT_NEXT(a_pause_ext, clk_i, rst_ni,
    accept_i && pend_pause_q && op_i == scd_pkg::OpRx, pend_ext_q && !pend_pause_q,
    "byte after pause prefix did not set extended")

endmodule

>>> src/scan_code_set1_decoder_top.sv
// Top level of the set-1 scan code decoder: request stage and result register.
// Depends on scd_pkg, scd_core and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: op_i = 0 hands
//   in a raw keyboard byte rx_byte_i, op_i = 1 pops the head of the key queue.
//   Output channel (out_valid_o / out_ready_i) returns one result per request:
//   the queue head after the request, queue_empty_o, led_write_o with the new
//   lock LED bits, and the shift, ctrl and alt modifiers.
//   From acceptance to out_valid_o, the request first updates the decoder
//   state and reads the queue RAM at the new head, and the registered RAM
//   data is then loaded into the result register. Throughput is one request
//   per cycle while the receiver takes results; the queue RAM has one write
//   and one read port and each request uses each of them at most once.
//   When the receiver stalls, the result register holds and one more request
//   waits in the read stage; in_ready_o then drops until the result is taken.
//   Reset clears the queue pointers, prefixes, modifiers and locks at once; the
//   queue RAM is not cleared, since only written entries are ever read.
`include "scan_code_set1_decoder_top_macros.svh"

module scan_code_set1_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] head_code_o,
  output logic       head_extended_o,
  output logic       queue_empty_o,
  output logic       led_write_o,
  output logic [2:0] led_bits_o,
  output logic       shift_down_o,
  output logic       ctrl_down_o,
  output logic       alt_down_o
);

  scd_pkg::stage_t            stage;
  scd_pkg::stage_t            s1_q;
  logic                       s1_valid_q;
  logic                       s1_move;
  logic                       accept;
  logic [scd_pkg::EntryW-1:0] rdata;
  logic [scd_pkg::EntryW-1:0] head_entry;

  logic                       out_valid_q;
  logic [6:0]                 head_code_q;
  logic                       head_ext_q;
  logic                       empty_q;
  logic                       led_q;
  logic [2:0]                 leds_q;
  logic [2:0]                 mods_q;

  assign s1_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  scd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_i),
    .rx_byte_i (rx_byte_i),
    .stage_o   (stage),
    .rdata_o   (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= stage;
    end
  end

  // An empty queue reports code zero whatever the RAM returned.
  always_comb begin
    head_entry = s1_q.fwd ? s1_q.fwd_entry : rdata;
    if (s1_q.empty) begin
      head_entry = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      head_code_q <= head_entry[scd_pkg::CodeW-1:0];
      head_ext_q  <= head_entry[scd_pkg::EntryW-1];
      empty_q     <= s1_q.empty;
      led_q       <= s1_q.led;
      leds_q      <= s1_q.leds;
      mods_q      <= s1_q.mods;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign head_code_o     = head_code_q;
  assign head_extended_o = head_ext_q;
  assign queue_empty_o   = empty_q;
  assign led_write_o     = led_q;
  assign led_bits_o      = leds_q;
  assign shift_down_o    = mods_q[scd_pkg::ModShift];
  assign ctrl_down_o     = mods_q[scd_pkg::ModCtrl];
  assign alt_down_o      = mods_q[scd_pkg::ModAlt];

  `SCD_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o && queue_empty_o,
    head_code_o == '0 && !head_extended_o, "empty queue shows a head entry")
  `SCD_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_move, s1_valid_q,
    "stalled request left the read stage")
  `SCD_ASSERT_IMPL(a_ready_full, clk_i, rst_ni, !in_ready_o,
    s1_valid_q && out_valid_q && !out_ready_i, "input stalled with room in the pipeline")

endmodule
